@@ sv/dbnt_pkg.sv @@
// shared types and constants for the debounced button note trigger
package dbnt_pkg;

  localparam int unsigned MAX_BUTTONS = 4;
  localparam int unsigned BUTTONS_DEFAULT = 4;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned SETUP_W = 56;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SETUP_BASE = 3'd1;

  // raw pin level that means pressed
  localparam logic LOW = 1'b0;

  localparam logic MODE_MOMENTARY = 1'b0;
  localparam logic MODE_LATCH = 1'b1;

  localparam logic [1:0] ACT_NOTE_OFF = 2'd0;
  localparam logic [1:0] ACT_NOTE_ON = 2'd1;

  // per-button setup word, lsb first: mom_en at bit 0 up to latch_off_vel at [55:49]
  typedef struct packed {
    logic [6:0] latch_off_vel;
    logic [6:0] latch_on_vel;
    logic [6:0] latch_note;
    logic [3:0] latch_channel;
    logic [1:0] release_action;
    logic [1:0] press_action;
    logic [6:0] mom_off_vel;
    logic [6:0] mom_on_vel;
    logic [6:0] mom_note;
    logic [3:0] mom_channel;
    logic       latch_en;
    logic       mom_en;
  } setup_t;

  typedef struct packed {
    logic [1:0] button_index;
    logic       source_mode;
    logic [1:0] note_action;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] on_velocity;
    logic [6:0] off_velocity;
  } msg_t;

  typedef struct packed {
    logic vld;
    msg_t msg;
  } slot_t;

endpackage

@@ sv/debounced_button_note_trigger.sv @@
// top level: poll register, per-button debounce, configuration and result buffer
//
//   channel | direction | handshake              | payload
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | now_ms_i, pin_levels_i
//   out     | out       | out_valid_o/out_ready_i | button_index_o .. last_o
//
// a poll waits in the poll register until the result buffer can load, then all buttons are evaluated at once
// and up to 2*BUTTONS messages load into the result buffer, one leaves per cycle while out_ready_i is high
// a poll with k messages holds the result buffer until all k are taken; a poll with none leaves it free
// the next poll is taken into the poll register while the buffer drains
// reset takes every button as released with the latch off; config is always ready
module debounced_button_note_trigger #(
  parameter int unsigned BUTTONS = dbnt_pkg::BUTTONS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbnt_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [dbnt_pkg::SETUP_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dbnt_pkg::TIME_W-1:0]         now_ms_i,
  input  logic [3:0]                          pin_levels_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          button_index_o,
  output logic                                source_mode_o,
  output logic [1:0]                          note_action_o,
  output logic [3:0]                          channel_o,
  output logic [6:0]                          note_o,
  output logic [6:0]                          on_velocity_o,
  output logic [6:0]                          off_velocity_o,
  output logic                                last_o
);

  localparam int unsigned NSLOT = 2 * BUTTONS;

  logic [dbnt_pkg::DEBOUNCE_W-1:0] debounce_q;
  dbnt_pkg::setup_t                setup_q [BUTTONS];

  logic                            in_vld_q;
  logic [dbnt_pkg::TIME_W-1:0]     now_q;
  logic [BUTTONS-1:0]              pins_q;

  logic                            can_load;
  logic                            commit;
  dbnt_pkg::slot_t                 slots [NSLOT];
  dbnt_pkg::msg_t                  msg;

  assign cfg_ready_o = 1'b1;
  assign commit = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= dbnt_pkg::DEBOUNCE_RESET;
      for (int b = 0; b < BUTTONS; b++) begin
        setup_q[b] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dbnt_pkg::REG_DEBOUNCE) begin
        debounce_q <= cfg_data_i[dbnt_pkg::DEBOUNCE_W-1:0];
      end
      for (int b = 0; b < BUTTONS; b++) begin
        if (cfg_index_i == dbnt_pkg::REG_SETUP_BASE + dbnt_pkg::CFG_INDEX_W'(b)) begin
          setup_q[b] <= dbnt_pkg::setup_t'(cfg_data_i);
        end
      end
    end
  end

  // poll register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q <= now_ms_i;
      pins_q <= pin_levels_i[BUTTONS-1:0];
    end
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_button
    dbnt_button u_button (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .commit_i       (commit),
      .button_index_i (2'(b)),
      .lvl_i          (pins_q[b]),
      .now_i          (now_q),
      .debounce_i     (debounce_q),
      .setup_i        (setup_q[b]),
      .mom_o          (slots[2*b]),
      .lat_o          (slots[2*b+1])
    );
  end

  dbnt_drain #(
    .NSLOT (NSLOT)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit),
    .slots_i     (slots),
    .out_ready_i (out_ready_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .msg_o       (msg),
    .last_o      (last_o)
  );

  assign button_index_o = msg.button_index;
  assign source_mode_o = msg.source_mode;
  assign note_action_o = msg.note_action;
  assign channel_o = msg.channel;
  assign note_o = msg.note;
  assign on_velocity_o = msg.on_velocity;
  assign off_velocity_o = msg.off_velocity;

`ifndef SYNTHESIS
  // a taken message that is not the last of its poll leaves more behind
  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("messages of a poll lost before last");

  // the poll side stalls only while results are pending
  a_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("poll stalled with empty result buffer");

  // latch messages only ever carry note on or note off
  a_latch_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && source_mode_o == dbnt_pkg::MODE_LATCH |->
      note_action_o == dbnt_pkg::ACT_NOTE_ON || note_action_o == dbnt_pkg::ACT_NOTE_OFF)
    else $error("latch message with bad action");
`endif

endmodule

@@ sv/dbnt_button.sv @@
// per-button debounce state, edge detection and message slots
module dbnt_button (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                commit_i,
  input  logic [1:0]                          button_index_i,
  input  logic                                lvl_i,
  input  logic [dbnt_pkg::TIME_W-1:0]         now_i,
  input  logic [dbnt_pkg::DEBOUNCE_W-1:0]     debounce_i,
  input  dbnt_pkg::setup_t                    setup_i,
  output dbnt_pkg::slot_t                     mom_o,
  output dbnt_pkg::slot_t                     lat_o
);

  logic                        raw_seen_q, raw_seen_d;
  logic                        stable_q, stable_d;
  logic                        latch_on_q, latch_on_d;
  logic [dbnt_pkg::TIME_W-1:0] change_time_q, change_time_d;

  logic                        changed;
  logic [dbnt_pkg::TIME_W-1:0] held;
  logic                        edge_hit;
  logic                        pressed;

  always_comb begin
    changed = (lvl_i != raw_seen_q);
    // a fresh change restarts the timer at now, so the held time is zero
    held = changed ? '0 : (now_i - change_time_q);
    edge_hit = (held >= {{(dbnt_pkg::TIME_W-dbnt_pkg::DEBOUNCE_W){1'b0}}, debounce_i})
               && (lvl_i != stable_q);
    pressed = (lvl_i == dbnt_pkg::LOW);

    mom_o.vld = edge_hit && setup_i.mom_en;
    mom_o.msg.button_index = button_index_i;
    mom_o.msg.source_mode = dbnt_pkg::MODE_MOMENTARY;
    mom_o.msg.note_action = pressed ? setup_i.press_action : setup_i.release_action;
    mom_o.msg.channel = setup_i.mom_channel;
    mom_o.msg.note = setup_i.mom_note;
    mom_o.msg.on_velocity = setup_i.mom_on_vel;
    mom_o.msg.off_velocity = setup_i.mom_off_vel;

    lat_o.vld = edge_hit && setup_i.latch_en && pressed;
    lat_o.msg.button_index = button_index_i;
    lat_o.msg.source_mode = dbnt_pkg::MODE_LATCH;
    lat_o.msg.note_action = latch_on_q ? dbnt_pkg::ACT_NOTE_OFF : dbnt_pkg::ACT_NOTE_ON;
    lat_o.msg.channel = setup_i.latch_channel;
    lat_o.msg.note = setup_i.latch_note;
    lat_o.msg.on_velocity = setup_i.latch_on_vel;
    lat_o.msg.off_velocity = setup_i.latch_off_vel;

    raw_seen_d = raw_seen_q;
    stable_d = stable_q;
    latch_on_d = latch_on_q;
    change_time_d = change_time_q;
    if (commit_i) begin
      raw_seen_d = lvl_i;
      if (changed) begin
        change_time_d = now_i;
      end
      if (edge_hit) begin
        stable_d = lvl_i;
      end
      if (lat_o.vld) begin
        latch_on_d = ~latch_on_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_seen_q <= 1'b1;
      stable_q <= 1'b1;
      latch_on_q <= 1'b0;
      change_time_q <= '0;
    end else begin
      raw_seen_q <= raw_seen_d;
      stable_q <= stable_d;
      latch_on_q <= latch_on_d;
      change_time_q <= change_time_d;
    end
  end

endmodule

@@ sv/dbnt_drain.sv @@
// result buffer: holds one poll's message slots and hands them out in order
module dbnt_drain #(
  parameter int unsigned NSLOT = 2 * dbnt_pkg::BUTTONS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  dbnt_pkg::slot_t       slots_i [NSLOT],
  input  logic                  out_ready_i,
  output logic                  can_load_o,
  output logic                  out_valid_o,
  output dbnt_pkg::msg_t        msg_o,
  output logic                  last_o
);

  localparam int unsigned IDX_W = $clog2(NSLOT);

  logic [NSLOT-1:0]  mask_q, mask_d;
  dbnt_pkg::msg_t    msgs_q [NSLOT];
  logic [NSLOT-1:0]  sel_onehot;
  logic [NSLOT-1:0]  rest;
  logic [IDX_W-1:0]  sel_idx;
  logic              out_take;

  always_comb begin
    // lowest pending slot goes first
    sel_onehot = mask_q & (~mask_q + 1'b1);
    rest = mask_q & ~sel_onehot;
    sel_idx = '0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        sel_idx = IDX_W'(k);
      end
    end
    out_valid_o = |mask_q;
    out_take = out_valid_o && out_ready_i;
    last_o = (rest == '0);
    msg_o = msgs_q[sel_idx];
    can_load_o = !out_valid_o || (out_take && last_o);

    mask_d = mask_q;
    if (load_i) begin
      for (int k = 0; k < NSLOT; k++) begin
        mask_d[k] = slots_i[k].vld;
      end
    end else if (out_take) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < NSLOT; k++) begin
        msgs_q[k] <= slots_i[k].msg;
      end
    end
  end

endmodule

@@ sim/dbnt_note_checker.sv @@
// checker for the debounced button note trigger: tracks buttons, predicts and compares messages
module dbnt_note_checker
  import dbnt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [SETUP_W-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [TIME_W-1:0]      now_ms_i,
  input  logic [3:0]             pin_levels_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [1:0]             button_index_i,
  input  logic                   source_mode_i,
  input  logic [1:0]             note_action_i,
  input  logic [3:0]             channel_i,
  input  logic [6:0]             note_i,
  input  logic [6:0]             on_velocity_i,
  input  logic [6:0]             off_velocity_i,
  input  logic                   last_i,
  output int unsigned            errors_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    msg_t msg;
    logic last;
  } note_msg_t;

  logic [DEBOUNCE_W-1:0] hold_ms;
  setup_t                setup_q    [MAX_BUTTONS];
  logic                  raw_seen   [MAX_BUTTONS];
  logic                  stable_lvl [MAX_BUTTONS];
  logic                  latch_on   [MAX_BUTTONS];
  logic [TIME_W-1:0]     changed_at [MAX_BUTTONS];
  note_msg_t             expected_notes [$];

  task automatic report(input string what);
    if (errors_o < PRINT_LIMIT) begin
      $display("[%0t] note checker: %s", $time, what);
    end
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // walks the buttons in index order; the last message of a poll gets its last flag
  task automatic predict_poll(input logic [TIME_W-1:0] now, input logic [3:0] pins);
    logic      lvl;
    logic      pressed;
    setup_t    s;
    note_msg_t m;
    note_msg_t held;
    logic      have_held;
    have_held = 1'b0;
    held = '0;
    for (int b = 0; b < MAX_BUTTONS; b++) begin
      s = setup_q[b];
      lvl = pins[b];
      if (lvl != raw_seen[b]) begin
        raw_seen[b] = lvl;
        changed_at[b] = now;
      end
      if (TIME_W'(now - changed_at[b]) < TIME_W'(hold_ms)) continue;
      if (lvl == stable_lvl[b]) continue;
      stable_lvl[b] = lvl;
      pressed = (lvl == LOW);
      if (s.mom_en) begin
        m.msg.button_index = 2'(b);
        m.msg.source_mode = MODE_MOMENTARY;
        m.msg.note_action = pressed ? s.press_action : s.release_action;
        m.msg.channel = s.mom_channel;
        m.msg.note = s.mom_note;
        m.msg.on_velocity = s.mom_on_vel;
        m.msg.off_velocity = s.mom_off_vel;
        m.last = 1'b0;
        if (have_held) expected_notes.push_back(held);
        held = m;
        have_held = 1'b1;
      end
      // latch only reacts to presses
      if (s.latch_en && pressed) begin
        latch_on[b] = !latch_on[b];
        m.msg.button_index = 2'(b);
        m.msg.source_mode = MODE_LATCH;
        m.msg.note_action = latch_on[b] ? ACT_NOTE_ON : ACT_NOTE_OFF;
        m.msg.channel = s.latch_channel;
        m.msg.note = s.latch_note;
        m.msg.on_velocity = s.latch_on_vel;
        m.msg.off_velocity = s.latch_off_vel;
        m.last = 1'b0;
        if (have_held) expected_notes.push_back(held);
        held = m;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_notes.push_back(held);
    end
  endtask

  task automatic check_message();
    note_msg_t want;
    if (expected_notes.size() == 0) begin
      report($sformatf("message from button %0d with nothing expected", button_index_i));
      return;
    end
    want = expected_notes.pop_front();
    check_field("button_index", 7'(button_index_i), 7'(want.msg.button_index));
    check_field("source_mode", 7'(source_mode_i), 7'(want.msg.source_mode));
    check_field("note_action", 7'(note_action_i), 7'(want.msg.note_action));
    check_field("channel", 7'(channel_i), 7'(want.msg.channel));
    check_field("note", note_i, want.msg.note);
    check_field("on_velocity", on_velocity_i, want.msg.on_velocity);
    check_field("off_velocity", off_velocity_i, want.msg.off_velocity);
    check_field("last", 7'(last_i), 7'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms = DEBOUNCE_RESET;
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        setup_q[b] = '0;
        raw_seen[b] = 1'b1;
        stable_lvl[b] = 1'b1;
        latch_on[b] = 1'b0;
        changed_at[b] = '0;
      end
      expected_notes.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_DEBOUNCE) begin
          hold_ms = cfg_data_i[DEBOUNCE_W-1:0];
        end else if (cfg_index_i >= REG_SETUP_BASE &&
                     cfg_index_i < REG_SETUP_BASE + MAX_BUTTONS) begin
          setup_q[cfg_index_i - REG_SETUP_BASE] = setup_t'(cfg_data_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_poll(now_ms_i, pin_levels_i);
      if (out_valid_i && out_ready_i) check_message();
      pending_o = expected_notes.size();
    end
  end

endmodule

@@ sim/tb_debounced_button_note_trigger.sv @@
// testbench top for the debounced button note trigger: stimulus, pacing and verdict
module tb_debounced_button_note_trigger;
  timeunit 1ns;
  timeprecision 1ps;
  import dbnt_pkg::*;

  localparam logic [1:0]  ACT_USER_LO = 2'd2;
  localparam logic [1:0]  ACT_USER_HI = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned POLLS_PER_PHASE = 38;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [SETUP_W-1:0]     cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [TIME_W-1:0]      now_ms_i = '0;
  logic [3:0]             pin_levels_i = '1;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             button_index_o;
  logic                   source_mode_o;
  logic [1:0]             note_action_o;
  logic [3:0]             channel_o;
  logic [6:0]             note_o;
  logic [6:0]             on_velocity_o;
  logic [6:0]             off_velocity_o;
  logic                   last_o;

  int unsigned            mismatches;
  int unsigned            awaited;
  bit                     steady = 1'b0;

  debounced_button_note_trigger u_top (.*);

  dbnt_note_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .now_ms_i       (now_ms_i),
    .pin_levels_i   (pin_levels_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_index_i (button_index_o),
    .source_mode_i  (source_mode_o),
    .note_action_i  (note_action_o),
    .channel_i      (channel_o),
    .note_i         (note_o),
    .on_velocity_i  (on_velocity_o),
    .off_velocity_i (off_velocity_o),
    .last_i         (last_o),
    .errors_o       (mismatches),
    .pending_o      (awaited)
  );

  always begin
    clk_i = 1'b0;
    #4ns;
    clk_i = 1'b1;
    #4ns;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 35);
  end

  // caller drops cfg_valid_i once its batch of writes is done
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [SETUP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // upper bits carry junk, only the low 16 count
  task automatic set_debounce(input logic [DEBOUNCE_W-1:0] ms);
    logic [SETUP_W-1:0] bits;
    bits = SETUP_W'({$urandom(), $urandom()});
    bits[DEBOUNCE_W-1:0] = ms;
    write_reg(REG_DEBOUNCE, bits);
  endtask

  function automatic setup_t random_setup();
    logic [SETUP_W-1:0] bits;
    bits = SETUP_W'({$urandom(), $urandom()});
    return setup_t'(bits);
  endfunction

  task automatic send_poll(input logic [TIME_W-1:0] now, input logic [3:0] pins);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i <= now;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // a poll with no messages may still be in flight when the count hits zero
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    setup_t            plan [MAX_BUTTONS];
    logic [3:0]        held;
    logic [3:0]        pins;
    logic [TIME_W-1:0] clock_ms;
    int unsigned       deb;
    int unsigned       roll;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // button 0 all ones, 1 momentary with the extra actions, 2 latch with zero fields, 3 off
    plan[0] = '1;
    plan[1] = random_setup();
    plan[1].mom_en = 1'b1;
    plan[1].latch_en = 1'b0;
    plan[1].press_action = ACT_USER_LO;
    plan[1].release_action = ACT_USER_HI;
    plan[2] = '0;
    plan[2].latch_en = 1'b1;
    plan[3] = random_setup();
    plan[3].mom_en = 1'b0;
    plan[3].latch_en = 1'b0;
    set_debounce(DEBOUNCE_RESET);
    for (int b = 0; b < MAX_BUTTONS; b++) begin
      write_reg(CFG_INDEX_W'(REG_SETUP_BASE + b), plan[b]);
    end
    cfg_valid_i <= 1'b0;

    send_poll(32'd0, 4'hF);
    send_poll(32'd5, 4'h0);
    send_poll(32'd10, 4'h0);
    send_poll(32'd25, 4'h0);
    // bounce back before the release settles
    send_poll(32'd30, 4'hF);
    send_poll(32'd35, 4'h0);
    send_poll(32'd60, 4'h0);
    send_poll(32'd70, 4'hF);
    send_poll(32'd90, 4'hF);
    // second press turns the latches off
    send_poll(32'd100, 4'h0);
    send_poll(32'd120, 4'h0);
    drain();

    // zero debounce accepts on the same poll
    set_debounce('0);
    cfg_valid_i <= 1'b0;
    send_poll(32'd130, 4'h5);
    send_poll(32'd130, 4'hA);
    send_poll(32'd131, 4'hF);
    drain();

    // hold time measured across the timestamp wrap
    set_debounce(DEBOUNCE_RESET);
    cfg_valid_i <= 1'b0;
    send_poll(32'hFFFF_FFF0, 4'h0);
    send_poll(32'hFFFF_FFFF, 4'h0);
    send_poll(32'h0000_0004, 4'h0);
    drain();

    set_debounce('1);
    cfg_valid_i <= 1'b0;
    send_poll(32'd1000, 4'hF);
    send_poll(32'd1000 + 32'd65534, 4'hF);
    send_poll(32'd1000 + 32'd65535, 4'hF);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       deb = 1;
        1:       deb = 0;
        2:       deb = $urandom_range(2, 6);
        3:       deb = 65535;
        4:       deb = $urandom_range(0, 12);
        default: deb = DEBOUNCE_RESET;
      endcase
      steady = (p == 2);
      set_debounce(DEBOUNCE_W'(deb));
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        write_reg(CFG_INDEX_W'(REG_SETUP_BASE + b), random_setup());
      end
      if (p == 1) begin
        for (int r = REG_SETUP_BASE + MAX_BUTTONS; r < 2 ** CFG_INDEX_W; r++) begin
          write_reg(CFG_INDEX_W'(r), SETUP_W'({$urandom(), $urandom()}));
        end
      end
      cfg_valid_i <= 1'b0;
      clock_ms = $urandom();
      held = 4'($urandom_range(0, 15));
      for (int i = 0; i < POLLS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) held = 4'($urandom_range(0, 15));
        pins = held;
        if (roll >= 25 && roll < 40) pins = held ^ 4'($urandom_range(1, 15));
        clock_ms = clock_ms + $urandom_range(0, deb < 4 ? 4 : deb);
        send_poll(clock_ms, pins);
        if (p == 4 && i == POLLS_PER_PHASE / 2) drain();
      end
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("tb_debounced_button_note_trigger: done, clean");
    end else begin
      $display("tb_debounced_button_note_trigger: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000ns;
    $display("tb_debounced_button_note_trigger: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dbnt_pkg.sv
sv/dbnt_button.sv
sv/dbnt_drain.sv
sv/debounced_button_note_trigger.sv
sim/dbnt_note_checker.sv
sim/tb_debounced_button_note_trigger.sv
